### hw/rtl/tap_pkg.sv
// Shared types and codes for the texture address point sampler.
package tap_pkg;

    localparam int COORD_W = 24;
    localparam int RGB_W   = 24;
    localparam int POS_W   = 8;
    localparam int MODE_W  = 3;
    localparam int SIZE_W  = 9;
    localparam int IDX_W   = 3;

    // Address mode codes; codes above MODE_MIRROR_ONCE behave as clamp.
    localparam logic [MODE_W-1:0] MODE_WRAP        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MIRROR      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLAMP       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BORDER      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MIRROR_ONCE = 3'd4;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_MODE_U     = 3'd0;
    localparam logic [IDX_W-1:0] REG_MODE_V     = 3'd1;
    localparam logic [IDX_W-1:0] REG_BORDER_RGB = 3'd2;
    localparam logic [IDX_W-1:0] REG_TEX_WIDTH  = 3'd3;
    localparam logic [IDX_W-1:0] REG_TEX_HEIGHT = 3'd4;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_MULT,
        S_ADDR,
        S_MEM,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic map_en;
        logic mult_en;
        logic addr_en;
        logic mem_en;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_write;
    } stat_t;

endpackage

### hw/rtl/tap_ctrl.sv
// Sequencer for the texture sampler: one item at a time through the datapath stages.
module tap_ctrl
    import tap_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    output cmd_t  cmd,
    input  stat_t stat
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MAP;
                end
            end
            S_MAP:
            begin
                cmd.map_en = 1'b1;
                // writes need no index multiply
                state_next = stat.is_write ? S_ADDR : S_MULT;
            end
            S_MULT:
            begin
                cmd.mult_en = 1'b1;
                state_next  = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.addr_en = 1'b1;
                state_next  = S_MEM;
            end
            S_MEM:
            begin
                cmd.mem_en = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/tap_datapath.sv
// Datapath: config registers, address mapping, index multiply, texel memory, result register.
module tap_datapath
    import tap_pkg::*;
#(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output stat_t                     stat,
    input  logic                      cfg_wr_en,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [RGB_W-1:0]          cfg_data,
    input  logic                      func,
    input  logic signed [COORD_W-1:0] u_coord,
    input  logic signed [COORD_W-1:0] v_coord,
    input  logic [POS_W-1:0]          texel_x,
    input  logic [POS_W-1:0]          texel_y,
    input  logic [RGB_W-1:0]          texel_rgb,
    output logic [RGB_W-1:0]          color,
    output logic                      used_border
);

    localparam int CW    = FRAC_BITS + 1;
    localparam int XW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = CW + XW;
    localparam logic [CW-1:0]      ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [COORD_W-1:0] FMASK = COORD_W'((64'd1 << FRAC_BITS) - 64'd1);

    // config
    logic [MODE_W-1:0] mode_u_reg;
    logic [MODE_W-1:0] mode_v_reg;
    logic [RGB_W-1:0]  border_rgb_reg;
    logic [SIZE_W-1:0] tex_width_reg;
    logic [SIZE_W-1:0] tex_height_reg;

    // captured item
    logic                      func_reg;
    logic signed [COORD_W-1:0] u_reg;
    logic signed [COORD_W-1:0] v_reg;
    logic [POS_W-1:0]          x_reg;
    logic [POS_W-1:0]          y_reg;
    logic [RGB_W-1:0]          rgb_reg;

    // pipeline
    logic [CW-1:0] u_map_reg;
    logic [CW-1:0] v_map_reg;
    logic          border_reg;
    logic [XW-1:0] tx_reg;
    logic [XW-1:0] ty_reg;
    logic [AW-1:0] addr_reg;
    logic          wr_ok_reg;
    logic [RGB_W-1:0] rd_data_reg;
    logic [RGB_W-1:0] color_reg;
    logic             used_border_reg;

    logic [RGB_W-1:0] mem [DEPTH];

    logic [CW:0]   u_res;
    logic [CW:0]   v_res;
    logic [XW-1:0] wm1;
    logic [XW-1:0] hm1;
    logic [PW-1:0] prod_u;
    logic [PW-1:0] prod_v;
    logic [AW-1:0] addr_next;
    logic          wr_ok_next;

    // Returns {border, mapped coordinate in [0, ONE]}.
    function automatic logic [CW:0] axis_map(input logic signed [COORD_W-1:0] c,
                                             input logic [MODE_W-1:0] mode);
        logic               neg;
        logic [COORD_W-1:0] mag;
        logic [COORD_W-1:0] n;
        logic [CW-1:0]      f;
        logic [CW-1:0]      cc;
        logic               hi;
        logic [CW:0]        r;
        neg = c[COORD_W-1];
        mag = neg ? COORD_W'(-c) : COORD_W'(c);
        n   = mag >> FRAC_BITS;
        f   = CW'(mag & FMASK);
        cc  = CW'(c);
        hi  = $signed({{2{c[COORD_W-1]}}, c}) > $signed((COORD_W + 2)'(ONE));
        case (mode)
            MODE_WRAP:
                r = {1'b0, (neg && (f != '0)) ? ONE - f : f};
            MODE_MIRROR:
                r = {1'b0, n[0] ? ONE - f : f};
            MODE_BORDER:
                r = (neg || hi) ? {1'b1, {CW{1'b0}}} : {1'b0, cc};
            MODE_MIRROR_ONCE:
            begin
                if (!neg)
                begin
                    if (n == '0)
                        r = {1'b0, f};
                    else if (n == COORD_W'(1))
                        r = {1'b0, ONE - f};
                    else
                        r = '0;
                end
                else
                begin
                    r = (n <= COORD_W'(1)) ? {1'b0, f} : {1'b0, ONE};
                end
            end
            default:
                r = hi ? {1'b0, ONE} : (neg ? '0 : {1'b0, cc});
        endcase
        return r;
    endfunction

    // size - 1, with zero acting as one and oversize as MAX_DIM
    function automatic logic [XW-1:0] size_m1(input logic [SIZE_W-1:0] s);
        logic [XW-1:0] r;
        if (s == '0)
            r = '0;
        else if (32'(s) > 32'(MAX_DIM))
            r = XW'(MAX_DIM - 1);
        else
            r = XW'(s - SIZE_W'(1));
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_u_reg     <= MODE_WRAP;
            mode_v_reg     <= MODE_WRAP;
            border_rgb_reg <= '0;
            tex_width_reg  <= SIZE_RESET;
            tex_height_reg <= SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODE_U:     mode_u_reg     <= cfg_data[MODE_W-1:0];
                REG_MODE_V:     mode_v_reg     <= cfg_data[MODE_W-1:0];
                REG_BORDER_RGB: border_rgb_reg <= cfg_data;
                REG_TEX_WIDTH:  tex_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_TEX_HEIGHT: tex_height_reg <= cfg_data[SIZE_W-1:0];
                default:        ;
            endcase
        end
    end

    assign u_res  = axis_map(u_reg, mode_u_reg);
    assign v_res  = axis_map(v_reg, mode_v_reg);
    assign wm1    = size_m1(tex_width_reg);
    assign hm1    = size_m1(tex_height_reg);
    assign prod_u = PW'(u_map_reg) * PW'(wm1);
    assign prod_v = PW'(v_map_reg) * PW'(hm1);

    always_comb
    begin
        if (func_reg == FUNC_WRITE)
        begin
            addr_next  = AW'(32'(y_reg) * 32'(MAX_DIM) + 32'(x_reg));
            wr_ok_next = (32'(x_reg) < 32'(MAX_DIM)) && (32'(y_reg) < 32'(MAX_DIM));
        end
        else
        begin
            addr_next  = AW'(32'(ty_reg) * 32'(MAX_DIM) + 32'(tx_reg));
            wr_ok_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            u_reg    <= u_coord;
            v_reg    <= v_coord;
            x_reg    <= texel_x;
            y_reg    <= texel_y;
            rgb_reg  <= texel_rgb;
        end
        if (cmd.map_en)
        begin
            u_map_reg  <= u_res[CW-1:0];
            v_map_reg  <= v_res[CW-1:0];
            border_reg <= u_res[CW] | v_res[CW];
        end
        if (cmd.mult_en)
        begin
            tx_reg <= XW'(prod_u >> FRAC_BITS);
            ty_reg <= XW'(prod_v >> FRAC_BITS);
        end
        if (cmd.addr_en)
        begin
            addr_reg  <= addr_next;
            wr_ok_reg <= wr_ok_next;
        end
        if (cmd.out_load)
        begin
            if (func_reg == FUNC_WRITE)
            begin
                color_reg       <= '0;
                used_border_reg <= 1'b0;
            end
            else if (border_reg)
            begin
                color_reg       <= border_rgb_reg;
                used_border_reg <= 1'b1;
            end
            else
            begin
                color_reg       <= rd_data_reg;
                used_border_reg <= 1'b0;
            end
        end
    end

    // texel memory, one port: write or registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_en)
        begin
            if (wr_ok_reg)
                mem[addr_reg] <= rgb_reg;
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign stat.is_write = (func_reg == FUNC_WRITE);
    assign color         = color_reg;
    assign used_border   = used_border_reg;

endmodule

### hw/rtl/texture_address_point_sampler.sv
// Top level of the texture address point sampler: texel store plus point sampling.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------------
//   input    | in_valid / in_ready   | func, u_coord, v_coord, texel_x, texel_y, texel_rgb
//   output   | out_valid / out_ready | color, used_border
//   config   | cfg_wr_en             | cfg_index, cfg_data
//
// One item in flight. A sample passes through map, index multiply, address, memory read
// and result load before output valid rises; a texel write skips the multiply. The next
// item is taken only once the current one has loaded its result, as the single-port texel
// memory and the stage sequence require. A finished result waits in the output
// register; while it is stalled the next item runs on and then holds in the done stage.
// Reset clears the sequencer and config registers; the texel store is not cleared.
module texture_address_point_sampler
    import tap_pkg::*;
#(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      func,
    input  logic signed [COORD_W-1:0] u_coord,
    input  logic signed [COORD_W-1:0] v_coord,
    input  logic [POS_W-1:0]          texel_x,
    input  logic [POS_W-1:0]          texel_y,
    input  logic [RGB_W-1:0]          texel_rgb,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [RGB_W-1:0]          color,
    output logic                      used_border,
    input  logic                      cfg_wr_en,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [RGB_W-1:0]          cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: walks each item through the stages, owns both handshakes
    tap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath: config, per-axis address modes, index multiply, texel memory
    tap_datapath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .u_coord     (u_coord),
        .v_coord     (v_coord),
        .texel_x     (texel_x),
        .texel_y     (texel_y),
        .texel_rgb   (texel_rgb),
        .color       (color),
        .used_border (used_border)
    );

endmodule

### hw/rtl/tap_checker.sv
// Port-level checks for the texture address point sampler, bound to the top level.
module tap_checker
    import tap_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [RGB_W-1:0] color,
    input logic             used_border
);

    // a held result must not move
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(color) && $stable(used_border))
        else $error("output changed while stalled");

    // one item at a time: no new transfer while the item just taken is in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input taken while an item is in flight");

    // a new result only comes out of the done stage, never straight from idle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an item in flight");

    // border flag only on a sample result, which is never back to back with a transfer in
    a_border_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !(out_valid && out_ready && $changed(used_border) && in_ready))
        else $error("output changed in the cycle after an input transfer");

endmodule

bind texture_address_point_sampler tap_checker u_tap_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .color       (color),
    .used_border (used_border)
);

### tb/sv/tap_sample_checker.sv
// Checker for the texture address point sampler: predicts each result and compares it.
module tap_sample_checker
    import tap_pkg::*;
#(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      func,
    input  logic signed [COORD_W-1:0] u_coord,
    input  logic signed [COORD_W-1:0] v_coord,
    input  logic [POS_W-1:0]          texel_x,
    input  logic [POS_W-1:0]          texel_y,
    input  logic [RGB_W-1:0]          texel_rgb,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [RGB_W-1:0]          color,
    input  logic                      used_border,
    input  logic                      cfg_wr_en,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [RGB_W-1:0]          cfg_data,
    output int                        errors,
    output int                        pending,
    output int                        checked,
    output int                        border_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_ONE = 1 << FRAC_BITS;

    typedef struct packed {
        logic [RGB_W-1:0] color;
        logic             used_border;
    } sample_result_t;

    logic [MODE_W-1:0] cur_mode_u;
    logic [MODE_W-1:0] cur_mode_v;
    logic [RGB_W-1:0]  cur_border;
    logic [SIZE_W-1:0] cur_width;
    logic [SIZE_W-1:0] cur_height;
    logic [RGB_W-1:0]  texels [0:MAX_DIM*MAX_DIM-1];
    sample_result_t    result_q [$];

    // Fold one coordinate into [0, one]; flags a border hit.
    function automatic int fold_axis(input int c, input logic [MODE_W-1:0] mode,
                                     output logic outside);
        int mag;
        int whole;
        int frac;
        outside = 1'b0;
        mag     = (c < 0) ? -c : c;
        whole   = mag >> FRAC_BITS;
        frac    = mag & (COORD_ONE - 1);
        case (mode)
            MODE_WRAP:
                return (c < 0 && frac != 0) ? COORD_ONE - frac : frac;
            MODE_MIRROR:
                return whole[0] ? COORD_ONE - frac : frac;
            MODE_BORDER:
            begin
                if (c < 0 || c > COORD_ONE)
                begin
                    outside = 1'b1;
                    return 0;
                end
                return c;
            end
            MODE_MIRROR_ONCE:
            begin
                if (c >= 0)
                    return (whole == 0) ? frac : ((whole == 1) ? COORD_ONE - frac : 0);
                return (whole <= 1) ? frac : COORD_ONE;
            end
            default:
                return (c > COORD_ONE) ? COORD_ONE : ((c < 0) ? 0 : c);
        endcase
    endfunction

    function automatic int used_size(input logic [SIZE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > MAX_DIM)
            return MAX_DIM;
        return s;
    endfunction

    function automatic sample_result_t predict_sample(input int u, input int v);
        logic           out_u;
        logic           out_v;
        int             pu;
        int             pv;
        int             col;
        int             row;
        sample_result_t r;
        pu = fold_axis(u, cur_mode_u, out_u);
        pv = fold_axis(v, cur_mode_v, out_v);
        if (out_u || out_v)
        begin
            r.color       = cur_border;
            r.used_border = 1'b1;
            return r;
        end
        col = (pu * (used_size(cur_width) - 1)) >> FRAC_BITS;
        row = (pv * (used_size(cur_height) - 1)) >> FRAC_BITS;
        r.color       = texels[row * MAX_DIM + col];
        r.used_border = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sample_result_t want;
        if (!rst_n)
        begin
            cur_mode_u  = MODE_WRAP;
            cur_mode_v  = MODE_WRAP;
            cur_border  = '0;
            cur_width   = SIZE_RESET;
            cur_height  = SIZE_RESET;
            result_q.delete();
            errors      = 0;
            checked     = 0;
            border_hits = 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_MODE_U:     cur_mode_u = cfg_data[MODE_W-1:0];
                    REG_MODE_V:     cur_mode_v = cfg_data[MODE_W-1:0];
                    REG_BORDER_RGB: cur_border = cfg_data;
                    REG_TEX_WIDTH:  cur_width  = cfg_data[SIZE_W-1:0];
                    REG_TEX_HEIGHT: cur_height = cfg_data[SIZE_W-1:0];
                    default:        ;
                endcase
            end

            // Output side first: a result and the next input can share an edge.
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual color %h border %b",
                             $time, color, used_border);
                end
                else
                begin
                    want = result_q.pop_front();
                    checked++;
                    if (want.used_border)
                        border_hits++;
                    if (color !== want.color)
                    begin
                        errors++;
                        $display("%0t: color mismatch, expected %h, actual %h",
                                 $time, want.color, color);
                    end
                    if (used_border !== want.used_border)
                    begin
                        errors++;
                        $display("%0t: used_border mismatch, expected %b, actual %b",
                                 $time, want.used_border, used_border);
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                if (func == FUNC_WRITE)
                begin
                    texels[int'(texel_y) * MAX_DIM + int'(texel_x)] = texel_rgb;
                    result_q.push_back('0);
                end
                else
                    result_q.push_back(predict_sample(u_coord, v_coord));
            end
            pending <= result_q.size();
        end
    end

endmodule

### tb/sv/texture_address_point_sampler_tb.sv
// Testbench top for the texture address point sampler: stimulus, idling and verdict.
module texture_address_point_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tap_pkg::*;

    localparam int MAX_DIM         = 256;
    localparam int FRAC_BITS       = 16;
    localparam int COORD_ONE       = 1 << FRAC_BITS;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 40;
    // Worst case is roughly 950 transfers with input gaps and receiver stalls; several times that.
    localparam int LIMIT           = 400000;
    // Longest path is a sample; give the tail a few times its length.
    localparam int SETTLE          = 20;

    // Mode code past the defined set; the block treats it as clamp.
    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      func;
    logic signed [COORD_W-1:0] u_coord;
    logic signed [COORD_W-1:0] v_coord;
    logic [POS_W-1:0]          texel_x;
    logic [POS_W-1:0]          texel_y;
    logic [RGB_W-1:0]          texel_rgb;
    logic                      out_valid;
    logic                      out_ready;
    logic [RGB_W-1:0]          color;
    logic                      used_border;
    logic                      cfg_wr_en;
    logic [IDX_W-1:0]          cfg_index;
    logic [RGB_W-1:0]          cfg_data;

    int errors;
    int pending;
    int checked;
    int border_hits;

    // Texels that hold a value; a sample must only ever land on one of these,
    // since the store is not cleared by reset.
    bit texel_loaded [0:MAX_DIM*MAX_DIM-1];
    int fill_w;
    int fill_h;
    int burst_left;
    bit steady;          // phase with neither side idling
    int writes_sent;
    int samples_sent;
    int settings_used;
    int cycle_count;

    int phase_w [PHASES] = '{256, 0, 511, 1, 5, 1, 300, 9, 4};
    int phase_h [PHASES] = '{1, 256, 1, 1, 4, 511, 0, 5, 4};

    texture_address_point_sampler #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .u_coord     (u_coord),
        .v_coord     (v_coord),
        .texel_x     (texel_x),
        .texel_y     (texel_y),
        .texel_rgb   (texel_rgb),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .color       (color),
        .used_border (used_border),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    tap_sample_checker #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .u_coord     (u_coord),
        .v_coord     (v_coord),
        .texel_x     (texel_x),
        .texel_y     (texel_y),
        .texel_rgb   (texel_rgb),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .color       (color),
        .used_border (used_border),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked),
        .border_hits (border_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop on a hung handshake.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random runs of ready and stall, ready throughout a steady phase.
    initial
    begin
        int run;
        logic level;
        forever
        begin
            run   = $urandom_range(1, 12);
            level = steady || ($urandom_range(0, 2) != 0);
            repeat (run)
            begin
                out_ready <= level;
                @(posedge clk);
            end
        end
    end

    // One transfer on the input channel. Bursts of items offered back to back,
    // broken by random gaps; valid drops only when a real gap follows.
    task automatic put_item(input logic f, input int u, input int v,
                            input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input logic [RGB_W-1:0] rgb);
        int gap;
        if (burst_left == 0)
        begin
            gap        = steady ? 0 : $urandom_range(0, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        func      <= f;
        u_coord   <= u[COORD_W-1:0];
        v_coord   <= v[COORD_W-1:0];
        texel_x   <= x;
        texel_y   <= y;
        texel_rgb <= rgb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        if (f == FUNC_WRITE)
        begin
            texel_loaded[int'(y) * MAX_DIM + int'(x)] = 1'b1;
            writes_sent++;
        end
        else
            samples_sent++;
    endtask

    // Coordinates ride along on writes and are ignored there.
    task automatic write_texel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                               input logic [RGB_W-1:0] rgb);
        put_item(FUNC_WRITE, $urandom, $urandom, x, y, rgb);
    endtask

    task automatic sample_at(input int u, input int v);
        put_item(FUNC_SAMPLE, u, v, POS_W'($urandom), POS_W'($urandom), RGB_W'($urandom));
    endtask

    // Hold off input until every expected result has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        burst_left = 0;
    endtask

    task automatic cfg_put(input logic [IDX_W-1:0] idx, input logic [RGB_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // New register setting while the block is idle, then load every texel of
    // the active rectangle that has not been written yet.
    task automatic apply_setting(input logic [MODE_W-1:0] mu, input logic [MODE_W-1:0] mv,
                                 input logic [RGB_W-1:0] border,
                                 input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        wait_idle();
        cfg_put(REG_MODE_U, RGB_W'(mu));
        cfg_put(REG_MODE_V, RGB_W'(mv));
        cfg_put(REG_BORDER_RGB, border);
        cfg_put(REG_TEX_WIDTH, RGB_W'(w));
        cfg_put(REG_TEX_HEIGHT, RGB_W'(h));
        cfg_wr_en <= 1'b0;
        settings_used++;
        // Zero acts as one, anything past the store acts as the full store.
        fill_w = (w == 0) ? 1 : ((w > MAX_DIM) ? MAX_DIM : w);
        fill_h = (h == 0) ? 1 : ((h > MAX_DIM) ? MAX_DIM : h);
        for (int y = 0; y < fill_h; y++)
            for (int x = 0; x < fill_w; x++)
                if (!texel_loaded[y * MAX_DIM + x])
                    write_texel(POS_W'(x), POS_W'(y), RGB_W'($urandom));
    endtask

    // Mix of full-range values, the few texels around the origin, values
    // hugging integer boundaries, and plain in-range values.
    function automatic int pick_coord();
        logic signed [COORD_W-1:0] raw;
        case ($urandom_range(0, 3))
            0:
            begin
                raw = COORD_W'($urandom);
                return raw;
            end
            1:       return int'($urandom_range(0, 6 * COORD_ONE)) - 3 * COORD_ONE;
            2:       return (int'($urandom_range(0, 6)) - 3) * COORD_ONE
                            + int'($urandom_range(0, 2)) - 1;
            default: return int'($urandom_range(0, COORD_ONE));
        endcase
    endfunction

    initial
    begin
        steady        = 1'b0;
        burst_left    = 0;
        writes_sent   = 0;
        samples_sent  = 0;
        settings_used = 0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        func         <= FUNC_WRITE;
        u_coord      <= '0;
        v_coord      <= '0;
        texel_x      <= '0;
        texel_y      <= '0;
        texel_rgb    <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_MODE_U;
        cfg_data     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: wrap and mirror on a 4x3 texture.
        apply_setting(MODE_WRAP, MODE_MIRROR, 24'hA5C3F0, 9'd4, 9'd3);
        write_texel(8'hFF, 8'hFF, 24'h000000);
        write_texel(8'h00, 8'h00, 24'hFFFFFF);
        sample_at(0, 0);                          // reads the texel just written
        sample_at(-32'sh8000, 32'sh18000);        // wrap of a negative fraction, odd mirror
        sample_at(-32'sh20000, -32'sh8000);       // whole negative wraps to zero, small negative mirror
        sample_at(32'sh7FFFFF, -32'sh800000);     // coordinate extremes
        sample_at(-32'sh800000, 32'sh7FFFFF);

        // Clamp on U, border on V, including both edges of [0,1].
        apply_setting(MODE_CLAMP, MODE_BORDER, 24'hFFFFFF, 9'd4, 9'd3);
        sample_at(32'sh20000, 32'sh10000);        // clamp above one, border exactly at one
        sample_at(-1, 0);                         // clamp below zero, border exactly at zero
        sample_at(32'sh8000, 32'sh10001);         // just past one
        sample_at(32'sh8000, -1);                 // just below zero

        // Mirror once on both axes, each sign and each range of the whole part.
        apply_setting(MODE_MIRROR_ONCE, MODE_MIRROR_ONCE, 24'h000000, 9'd4, 9'd3);
        sample_at(32'sh4000, 32'sh14000);
        sample_at(32'sh24000, -32'sh14000);
        sample_at(-32'sh28000, -32'sh4000);

        // Border on U, spare mode code on V, zero width.
        apply_setting(MODE_BORDER, MODE_SPARE, 24'h5A3C96, 9'd0, 9'd3);
        sample_at(32'sh10001, 32'sh8000);
        sample_at(32'sh10000, 32'sh50000);
        sample_at(0, -32'sh30000);

        // Random phases: every mode code on each axis, sizes from one texel up
        // to the full store, zero and oversize register values included.
        for (int p = 0; p < PHASES; p++)
        begin
            apply_setting(MODE_W'(p), MODE_W'(p * 3 + 1),
                          (p == 1) ? 24'hFFFFFF : ((p == 2) ? 24'h000000 : RGB_W'($urandom)),
                          SIZE_W'(phase_w[p]), SIZE_W'(phase_h[p]));
            steady = (p % 3 == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Now and then let the pipe run dry before going on.
                if ($urandom_range(0, 79) == 0)
                    wait_idle();
                case ($urandom_range(0, 9))
                    0, 1:
                        write_texel(POS_W'($urandom_range(0, fill_w - 1)),
                                    POS_W'($urandom_range(0, fill_h - 1)), RGB_W'($urandom));
                    2:
                        write_texel(POS_W'($urandom), POS_W'($urandom), RGB_W'($urandom));
                    default:
                        sample_at(pick_coord(), pick_coord());
                endcase
            end
            steady = 1'b0;
        end

        wait_idle();
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d texel writes and %0d samples over %0d register settings,",
                 writes_sent, samples_sent, settings_used);
        $display("%0d results checked (%0d on the border color) in %0d cycles.",
                 checked, border_hits, cycle_count);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### texture_address_point_sampler.f
hw/rtl/tap_pkg.sv
hw/rtl/tap_ctrl.sv
hw/rtl/tap_datapath.sv
hw/rtl/texture_address_point_sampler.sv
hw/rtl/tap_checker.sv
tb/sv/tap_sample_checker.sv
tb/sv/texture_address_point_sampler_tb.sv
